/* design/tbdg_pkg.sv */
// Shared types and constants for the two-button debounce and gesture block.
`timescale 1ns / 1ps

package tbdg_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned CFG_W         = 16;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned MAX_EV_W      = 3;
  localparam int unsigned RESULT_CAP    = 4;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_EVENTS = 2'd2;

  localparam logic [CFG_W-1:0]    DEBOUNCE_RST   = 16'd20;
  localparam logic [CFG_W-1:0]    LONG_PRESS_RST = 16'd1000;
  localparam logic [MAX_EV_W-1:0] MAX_EVENTS_RST = 3'd4;
  localparam logic [MAX_EV_W-1:0] EV_CAP         = 3'd4;

  typedef enum logic [1:0] {
    ACT_DOWN    = 2'd0,
    ACT_UP      = 2'd1,
    ACT_PRESSED = 2'd2,
    ACT_LONG    = 2'd3
  } act_e;

  // events raised by one button in one poll, at most two
  typedef struct packed {
    logic [1:0] num;
    act_e       act0;
    act_e       act1;
  } btn_ev_t;

  // one queued result word
  typedef struct packed {
    logic btn;
    act_e act;
  } evt_t;

endpackage

/* design/tbdg_button.sv */
// Debounce filter, press timer and gesture decode for one button.
`timescale 1ns / 1ps

module tbdg_button import tbdg_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 raw_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic [CFG_W-1:0]     deb_i,
  input  logic [CFG_W-1:0]     lpt_i,
  output btn_ev_t              ev_o
);

  logic                 filt_q, filt_d;
  logic                 settle_act_q, settle_act_d;
  logic [TIME_BITS-1:0] settle_start_q, settle_start_d;
  logic [TIME_BITS-1:0] press_start_q, press_start_d;
  logic                 long_q, long_d;

  logic [TIME_BITS-1:0] settle_age;
  logic [TIME_BITS-1:0] hold_age;
  logic                 rise, fall, long_hit, long_eff;

  assign settle_age = now_i - settle_start_q;

  always_comb begin
    filt_d         = filt_q;
    settle_act_d   = 1'b0;
    settle_start_d = settle_start_q;
    if (raw_i != filt_q) begin
      if (!settle_act_q) begin
        settle_act_d   = 1'b1;
        settle_start_d = now_i;
      end else if (settle_age >= TIME_BITS'(deb_i)) begin
        filt_d = raw_i;
      end else begin
        settle_act_d = 1'b1;
      end
    end
  end

  assign rise = filt_d & ~filt_q;
  assign fall = ~filt_d & filt_q;

  // a fresh press starts its hold at zero
  assign hold_age = rise ? '0 : (now_i - press_start_q);
  assign long_eff = rise ? 1'b0 : long_q;
  assign long_hit = filt_d & ~long_eff & (hold_age >= TIME_BITS'(lpt_i));

  assign press_start_d = rise ? now_i : press_start_q;
  assign long_d        = long_hit | long_eff;

  always_comb begin
    ev_o = '{num: 2'd0, act0: ACT_DOWN, act1: ACT_DOWN};
    if (rise && long_hit) begin
      ev_o = '{num: 2'd2, act0: ACT_DOWN, act1: ACT_LONG};
    end else if (rise) begin
      ev_o = '{num: 2'd1, act0: ACT_DOWN, act1: ACT_DOWN};
    end else if (long_hit) begin
      ev_o = '{num: 2'd1, act0: ACT_LONG, act1: ACT_DOWN};
    end else if (fall) begin
      ev_o = '{num: long_q ? 2'd1 : 2'd2, act0: ACT_UP, act1: ACT_PRESSED};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q         <= 1'b0;
      settle_act_q   <= 1'b0;
      settle_start_q <= '0;
      press_start_q  <= '0;
      long_q         <= 1'b0;
    end else if (en_i) begin
      filt_q         <= filt_d;
      settle_act_q   <= settle_act_d;
      settle_start_q <= settle_start_d;
      press_start_q  <= press_start_d;
      long_q         <= long_d;
    end
  end

endmodule

/* design/two_button_debounce_gesture_events_top.sv */
// Top level: two debounced buttons, event merge and two-slot result buffer.
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+---------------------------
//  in      | in_valid_i / in_ready_o                   | now_ms, raw_a, raw_b
//  out     | out_valid_o / out_ready_i                 | button_id, action, last
//  cfg     | cfg_we_i, cfg_idx_i                       | cfg_data_i, no read-back
//
// When a poll is taken, both buttons update and their events are
// merged into a batch of up to four words in that same edge.
// A batch is sent on the result port one word a cycle while out_ready_i
// is high; a low out_ready_i holds the current word.
// A second batch slot lets the next poll in while the current batch drains;
// in_ready_o drops only while both slots are held. Polls with no event pass
// straight through. Reset loads the register defaults; no clearing pass.
`timescale 1ns / 1ps

module two_button_debounce_gesture_events_top import tbdg_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          now_ms_i,
  input  logic                 raw_a_i,
  input  logic                 raw_b_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 button_id_o,
  output logic [1:0]           action_o,
  output logic                 last_o
);

  logic [CFG_W-1:0]    deb_q, lpt_q;
  logic [MAX_EV_W-1:0] max_ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q    <= DEBOUNCE_RST;
      lpt_q    <= LONG_PRESS_RST;
      max_ev_q <= MAX_EVENTS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEBOUNCE:   deb_q    <= cfg_data_i;
        CFG_LONG_PRESS: lpt_q    <= cfg_data_i;
        CFG_MAX_EVENTS: max_ev_q <= cfg_data_i[MAX_EV_W-1:0];
        default: ;
      endcase
    end
  end

  logic                 in_fire;
  logic [TIME_BITS-1:0] now_t;
  btn_ev_t              ev_a, ev_b;

  assign in_fire = in_valid_i & in_ready_o;
  assign now_t   = TIME_BITS'(now_ms_i);

  tbdg_button #(.TIME_BITS(TIME_BITS)) u_btn_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_fire),
    .raw_i  (raw_a_i),
    .now_i  (now_t),
    .deb_i  (deb_q),
    .lpt_i  (lpt_q),
    .ev_o   (ev_a)
  );

  tbdg_button #(.TIME_BITS(TIME_BITS)) u_btn_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_fire),
    .raw_i  (raw_b_i),
    .now_i  (now_t),
    .deb_i  (deb_q),
    .lpt_i  (lpt_q),
    .ev_o   (ev_b)
  );

  // merge: button 0 words first, then button 1, then clip to the limit
  evt_t                new_ev [RESULT_CAP];
  logic [MAX_EV_W-1:0] total, limit, new_cnt;

  always_comb begin
    new_ev[0] = (ev_a.num != 2'd0) ? '{btn: 1'b0, act: ev_a.act0}
                                   : '{btn: 1'b1, act: ev_b.act0};
    if (ev_a.num == 2'd2) begin
      new_ev[1] = '{btn: 1'b0, act: ev_a.act1};
      new_ev[2] = '{btn: 1'b1, act: ev_b.act0};
    end else if (ev_a.num == 2'd1) begin
      new_ev[1] = '{btn: 1'b1, act: ev_b.act0};
      new_ev[2] = '{btn: 1'b1, act: ev_b.act1};
    end else begin
      new_ev[1] = '{btn: 1'b1, act: ev_b.act1};
      new_ev[2] = '{btn: 1'b1, act: ev_b.act1};
    end
    new_ev[3] = '{btn: 1'b1, act: ev_b.act1};
  end

  assign total   = MAX_EV_W'(ev_a.num) + MAX_EV_W'(ev_b.num);
  assign limit   = (max_ev_q > EV_CAP) ? EV_CAP : max_ev_q;
  assign new_cnt = (total < limit) ? total : limit;

  // front slot drives the port, back slot catches the next batch
  logic                fvalid_q, bvalid_q;
  logic [1:0]          fidx_q;
  logic [MAX_EV_W-1:0] fcnt_q, bcnt_q;
  evt_t                fev_q [RESULT_CAP];
  evt_t                bev_q [RESULT_CAP];
  logic                new_ok, out_fire, front_done, front_free;
  logic                load_front, load_back, move_back;

  assign in_ready_o  = ~bvalid_q;
  assign new_ok      = in_fire & (new_cnt != '0);
  assign out_valid_o = fvalid_q;
  assign button_id_o = fev_q[fidx_q].btn;
  assign action_o    = fev_q[fidx_q].act;
  assign last_o      = (MAX_EV_W'(fidx_q) + MAX_EV_W'(1)) == fcnt_q;
  assign out_fire    = out_valid_o & out_ready_i;
  assign front_done  = out_fire & last_o;
  assign front_free  = ~fvalid_q | front_done;
  assign move_back   = front_free & bvalid_q;
  assign load_front  = front_free & ~bvalid_q & new_ok;
  assign load_back   = ~front_free & new_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fvalid_q <= 1'b0;
      bvalid_q <= 1'b0;
      fidx_q   <= 2'd0;
    end else begin
      if (front_free) begin
        fvalid_q <= bvalid_q | new_ok;
        fidx_q   <= 2'd0;
        bvalid_q <= 1'b0;
      end else begin
        if (out_fire) begin
          fidx_q <= fidx_q + 2'd1;
        end
        if (load_back) begin
          bvalid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move_back) begin
      fev_q  <= bev_q;
      fcnt_q <= bcnt_q;
    end else if (load_front) begin
      fev_q  <= new_ev;
      fcnt_q <= new_cnt;
    end
    if (load_back) begin
      bev_q  <= new_ev;
      bcnt_q <= new_cnt;
    end
  end

`ifndef SYNTHESIS
  a_back_needs_front: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bvalid_q |-> fvalid_q)
    else $error("back batch held with front slot empty");

  a_front_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fvalid_q |-> (fcnt_q != '0) && (fcnt_q <= EV_CAP)
                 && (MAX_EV_W'(fidx_q) < fcnt_q))
    else $error("front batch count or index out of range");

  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !last_o) |=> fvalid_q && (fidx_q == 2'($past(fidx_q) + 2'd1)))
    else $error("word index did not advance within a batch");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bvalid_q && !front_done) |=> bvalid_q)
    else $error("back batch lost before the front drained");
`endif

endmodule

/* bench/gesture_event_monitor.sv */
// Channel monitor: predicts the gesture events of each poll and compares the words that come out.
`timescale 1ns / 1ps

module gesture_event_monitor import tbdg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [31:0]          now_ms_i,
  input  logic                 raw_a_i,
  input  logic                 raw_b_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic                 button_id_i,
  input  logic [1:0]           action_i,
  input  logic                 last_i,
  output int unsigned          fail_count_o,
  output int unsigned          events_due_o
);

  typedef struct packed {
    logic btn;
    act_e act;
    logic fin;
  } gesture_word_t;

  // per-button debounce and gesture state
  logic        level_q   [2];
  logic        settling  [2];
  logic [31:0] settle_t0 [2];
  logic [31:0] press_t0  [2];
  logic        long_seen [2];

  logic [CFG_W-1:0]    dbnc_cfg;
  logic [CFG_W-1:0]    long_ms;
  logic [MAX_EV_W-1:0] event_limit;

  gesture_word_t poll_words[$];
  gesture_word_t events_due[$];
  gesture_word_t want;

  function automatic void emit(input int b, input act_e a, input int unsigned cap);
    gesture_word_t w;
    w.btn = 1'(b);
    w.act = a;
    w.fin = 1'b0;
    if (poll_words.size() < cap) poll_words.push_back(w);
  endfunction

  function automatic void advance_button(input int b, input logic raw, input logic [31:0] t,
                                         input int unsigned cap);
    logic        was;
    logic [31:0] held_ms;
    was = level_q[b];
    if (raw != level_q[b]) begin
      if (!settling[b]) begin
        // the arming poll never takes the new level
        settling[b]  = 1'b1;
        settle_t0[b] = t;
      end else begin
        held_ms = t - settle_t0[b];
        if (held_ms >= {16'd0, dbnc_cfg}) begin
          level_q[b]  = raw;
          settling[b] = 1'b0;
        end
      end
    end else begin
      settling[b] = 1'b0;
    end

    if (level_q[b] && !was) begin
      press_t0[b]  = t;
      long_seen[b] = 1'b0;
      emit(b, ACT_DOWN, cap);
    end

    held_ms = t - press_t0[b];
    if (level_q[b] && !long_seen[b] && held_ms >= {16'd0, long_ms}) begin
      long_seen[b] = 1'b1;
      emit(b, ACT_LONG, cap);
      return;
    end

    if (!level_q[b] && was) begin
      emit(b, ACT_UP, cap);
      if (!long_seen[b]) emit(b, ACT_PRESSED, cap);
    end
  endfunction

  function automatic void predict_poll(input logic [31:0] t, input logic a, input logic b);
    int unsigned   cap;
    gesture_word_t w;
    // limits above the result cap behave as the cap
    cap = (event_limit > EV_CAP) ? RESULT_CAP : int'(event_limit);
    poll_words.delete();
    advance_button(0, a, t, cap);
    advance_button(1, b, t, cap);
    for (int i = 0; i < poll_words.size(); i++) begin
      w = poll_words[i];
      w.fin = (i == poll_words.size() - 1);
      events_due.push_back(w);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < 2; b++) begin
        level_q[b]   = 1'b0;
        settling[b]  = 1'b0;
        settle_t0[b] = '0;
        press_t0[b]  = '0;
        long_seen[b] = 1'b0;
      end
      dbnc_cfg     = DEBOUNCE_RST;
      long_ms      = LONG_PRESS_RST;
      event_limit  = MAX_EVENTS_RST;
      events_due.delete();
      fail_count_o = 0;
    end else begin
      // a word leaving now belongs to an earlier poll, so check before predicting
      if (out_valid_i && out_ready_i) begin
        if (events_due.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected word btn=%0d act=%0d last=%0d", $realtime,
                     button_id_i, action_i, last_i);
          fail_count_o++;
        end else begin
          want = events_due.pop_front();
          if (button_id_i !== want.btn || action_i !== want.act || last_i !== want.fin) begin
            if (fail_count_o < 10)
              $display("%0t: word mismatch exp btn=%0d act=%0d last=%0d, got %0d/%0d/%0d",
                       $realtime, want.btn, want.act, want.fin,
                       button_id_i, action_i, last_i);
            fail_count_o++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DEBOUNCE:   dbnc_cfg    = cfg_data_i;
          CFG_LONG_PRESS: long_ms     = cfg_data_i;
          CFG_MAX_EVENTS: event_limit = cfg_data_i[MAX_EV_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) predict_poll(now_ms_i, raw_a_i, raw_b_i);
    end
    events_due_o = events_due.size();
  end

endmodule

/* bench/testbench.sv */
// Testbench top: poll stimulus, handshake idling, register settings and the final verdict.
`timescale 1ns / 1ps

module testbench;
  import tbdg_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped index, must be ignored
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD    = 80;
  localparam int unsigned NUM_PHASES   = 10;
  localparam int unsigned PHASE_POLLS  = 48;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  logic [31:0]          now_ms    = '0;
  logic                 raw_a     = 1'b0;
  logic                 raw_b     = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 button_id;
  logic [1:0]           action;
  logic                 last_flag;

  int unsigned fail_count;
  int unsigned events_due;
  int unsigned quiet_cycles = 0;
  int unsigned rx_words     = 0;
  int unsigned dbnc_now     = DEBOUNCE_RST;
  int unsigned lp_now       = LONG_PRESS_RST;
  logic        tx_fast      = 1'b0;
  logic        rx_fast      = 1'b0;
  logic [31:0] clock_ms     = '0;
  logic        level_a      = 1'b0;
  logic        level_b      = 1'b0;

  int unsigned phase_dbnc  [NUM_PHASES] = '{0, 0, 65535, 3, 5, 2, 10, 1, 65535, 0};
  int unsigned phase_lp    [NUM_PHASES] = '{0, 65535, 65535, 40, 30, 15, 100, 8, 0, 12};
  int unsigned phase_limit [NUM_PHASES] = '{4, 4, 7, 3, 0, 1, 2, 5, 6, 4};

  two_button_debounce_gesture_events_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .now_ms_i    (now_ms),
    .raw_a_i     (raw_a),
    .raw_b_i     (raw_b),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .button_id_o (button_id),
    .action_o    (action),
    .last_o      (last_flag)
  );

  gesture_event_monitor monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .now_ms_i     (now_ms),
    .raw_a_i      (raw_a),
    .raw_b_i      (raw_b),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .button_id_i  (button_id),
    .action_i     (action),
    .last_i       (last_flag),
    .fail_count_o (fail_count),
    .events_due_o (events_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random hold-off per word, plus two long stalls to back the block up
  initial begin
    int unsigned hold;
    forever begin
      if (rx_words == 25 || rx_words == 180) hold = LONG_HOLD;
      else hold = rx_fast ? 0 : $urandom_range(0, 11);
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      rx_words++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_poll(input logic [31:0] t, input logic a, input logic b);
    int unsigned gap;
    gap = tx_fast ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    now_ms   <= t;
    raw_a    <= a;
    raw_b    <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // idle: every predicted word out, then room for a silent poll to finish
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(posedge clk); while (events_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_config(input logic [CFG_W-1:0] dbnc, input logic [CFG_W-1:0] lp,
                             input logic [MAX_EV_W-1:0] limit);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SPARE;
    cfg_data <= CFG_W'($urandom());
    @(posedge clk);
    cfg_idx  <= CFG_DEBOUNCE;
    cfg_data <= dbnc;
    @(posedge clk);
    cfg_idx  <= CFG_LONG_PRESS;
    cfg_data <= lp;
    @(posedge clk);
    // upper data bits are junk, only the low bits belong to the limit
    cfg_idx  <= CFG_MAX_EVENTS;
    cfg_data <= {(CFG_W - MAX_EV_W)'($urandom()), limit};
    @(posedge clk);
    cfg_we   <= 1'b0;
    dbnc_now = dbnc;
    lp_now   = lp;
  endtask

  task automatic random_polls(input int unsigned count);
    int unsigned pick;
    int unsigned span;
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        clock_ms = $urandom();
      end else begin
        case (pick % 3)
          0:       span = 3;
          1:       span = dbnc_now + 4;
          default: span = dbnc_now + lp_now + 4;
        endcase
        clock_ms = clock_ms + $urandom_range(0, span);
      end
      if ($urandom_range(0, 3) == 0) level_a = ~level_a;
      if ($urandom_range(0, 3) == 0) level_b = ~level_b;
      send_poll(clock_ms, level_a, level_b);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register defaults: clicks, bounce, four words in one poll, long press, time wrap
    send_poll(32'h0000_0000, 1'b0, 1'b0);
    send_poll(32'd5,    1'b1, 1'b1);
    send_poll(32'd30,   1'b1, 1'b1);
    send_poll(32'd40,   1'b1, 1'b0);
    send_poll(32'd45,   1'b1, 1'b1);
    send_poll(32'd50,   1'b1, 1'b0);
    send_poll(32'd75,   1'b0, 1'b0);
    send_poll(32'd100,  1'b0, 1'b0);
    send_poll(32'd200,  1'b1, 1'b1);
    send_poll(32'd220,  1'b1, 1'b1);
    send_poll(32'd300,  1'b0, 1'b0);
    send_poll(32'd330,  1'b0, 1'b0);
    send_poll(32'd400,  1'b1, 1'b0);
    send_poll(32'd420,  1'b1, 1'b0);
    send_poll(32'd1420, 1'b1, 1'b0);
    send_poll(32'd1430, 1'b0, 1'b0);
    send_poll(32'd1450, 1'b0, 1'b0);
    send_poll(32'hFFFF_FFF0, 1'b0, 1'b1);
    send_poll(32'h0000_0010, 1'b0, 1'b1);
    send_poll(32'hFFFF_FFFF, 1'b0, 1'b1);
    send_poll(32'h0000_0000, 1'b0, 1'b0);
    send_poll(32'h7FFF_FFFF, 1'b0, 1'b0);
    wait_quiet();

    // zero debounce still needs two polls; zero long-press time; limit of three drops a word
    load_config(16'd0, 16'd0, 3'd3);
    send_poll(32'd1000, 1'b1, 1'b1);
    send_poll(32'd1000, 1'b1, 1'b1);
    send_poll(32'd1001, 1'b0, 1'b0);
    send_poll(32'd1001, 1'b0, 1'b0);
    clock_ms = 32'd2000;
    wait_quiet();

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      load_config(CFG_W'(phase_dbnc[p]), CFG_W'(phase_lp[p]), MAX_EV_W'(phase_limit[p]));
      tx_fast = (p % 3 == 1);
      rx_fast = (p % 4 == 2);
      random_polls(PHASE_POLLS);
      wait_quiet();
    end

    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
